/* hdl/swr_pkg.sv */
// Shared types, codes and reset constants of the wheel setpoint ramp block.
// No dependencies; used by every module of the block.
package swr_pkg;

    localparam int SPEED_W = 10;
    localparam int SP_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_CMD  = 2'd2;

    localparam logic [2:0] KEY_ARM  = 3'd1;
    localparam logic [2:0] KEY_FWD  = 3'd2;
    localparam logic [2:0] KEY_BWD  = 3'd3;
    localparam logic [2:0] KEY_STOP = 3'd4;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;
    localparam logic [1:0] DIR_BAD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_LF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_RF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_BWD = 3'd4;

    localparam logic [SPEED_W-1:0]     RST_CRUISE   = 10'd200;
    localparam logic [SPEED_W-1:0]     RST_STEP     = 10'd4;
    localparam logic [SPEED_W-1:0]     RST_KICK_LF  = 10'd100;
    localparam logic [SPEED_W-1:0]     RST_KICK_RF  = 10'd130;
    localparam logic signed [SP_W-1:0] RST_KICK_BWD = -11'sd120;

    typedef struct packed {
        logic [SPEED_W-1:0]     cruise;
        logic [SPEED_W-1:0]     step;
        logic [SPEED_W-1:0]     kick_lf;
        logic [SPEED_W-1:0]     kick_rf;
        logic signed [SP_W-1:0] kick_back;
    } t_cfg;

endpackage

/* hdl/swr_cfg_regs.sv */
// Configuration register file: cruise speed, ramp step and kick values.
// Depends on swr_pkg.
module swr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [swr_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [swr_pkg::CFG_DATA_W-1:0]   i_data,
    output swr_pkg::t_cfg                    o_cfg
);

    swr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise    <= swr_pkg::RST_CRUISE;
            r_cfg.step      <= swr_pkg::RST_STEP;
            r_cfg.kick_lf   <= swr_pkg::RST_KICK_LF;
            r_cfg.kick_rf   <= swr_pkg::RST_KICK_RF;
            r_cfg.kick_back <= swr_pkg::RST_KICK_BWD;
        end else if (i_wr) begin
            unique case (i_idx)
                swr_pkg::CFG_CRUISE:   r_cfg.cruise    <= i_data[swr_pkg::SPEED_W-1:0];
                swr_pkg::CFG_STEP:     r_cfg.step      <= i_data[swr_pkg::SPEED_W-1:0];
                swr_pkg::CFG_KICK_LF:  r_cfg.kick_lf   <= i_data[swr_pkg::SPEED_W-1:0];
                swr_pkg::CFG_KICK_RF:  r_cfg.kick_rf   <= i_data[swr_pkg::SPEED_W-1:0];
                swr_pkg::CFG_KICK_BWD: r_cfg.kick_back <= $signed(i_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/swr_wheel_ramp.sv */
// One wheel's setpoint step toward its destination, with the start kick and clamp.
// Depends on swr_pkg.
module swr_wheel_ramp (
    input  logic signed [swr_pkg::SP_W-1:0]  i_sp,
    input  logic signed [swr_pkg::SP_W-1:0]  i_dest,
    input  logic [swr_pkg::SPEED_W-1:0]      i_step,
    input  logic [swr_pkg::SPEED_W-1:0]      i_kick_fwd,
    input  logic signed [swr_pkg::SP_W-1:0]  i_kick_back,
    output logic signed [swr_pkg::SP_W-1:0]  o_sp
);

    localparam int XW = swr_pkg::SP_W + 1;

    logic signed [XW-1:0] sp_x;
    logic signed [XW-1:0] dest_x;
    logic signed [XW-1:0] up;
    logic signed [XW-1:0] dn;
    logic signed [XW-1:0] cand;
    logic signed [XW-1:0] res;
    logic                 at_zero;

    assign sp_x    = XW'(i_sp);
    assign dest_x  = XW'(i_dest);
    assign up      = sp_x + $signed({2'b00, i_step});
    assign dn      = sp_x - $signed({2'b00, i_step});
    assign at_zero = (i_sp == '0);

    always_comb begin
        cand = sp_x;
        res  = sp_x;
        if (sp_x < dest_x) begin
            cand = at_zero ? $signed({2'b00, i_kick_fwd}) : up;
            res  = (cand > dest_x) ? dest_x : cand;
        end else if (sp_x > dest_x) begin
            cand = at_zero ? XW'(i_kick_back) : dn;
            res  = (cand < dest_x) ? dest_x : cand;
        end
    end

    assign o_sp = res[swr_pkg::SP_W-1:0];

endmodule

/* hdl/wheel_setpoint_ramp_with_kick.sv */
// Wheel setpoint ramp: one request in per cycle while the output is not stalled,
// one result out per request. A request is taken into an input register; when
// the output stage advances, the state/result register is loaded with the full
// state after it and the result becomes valid. Throughput is one request per cycle
// while no result is held by i_out_ready; the update uses both wheel ramps' logic.
// Configuration writes are taken every cycle and belong to idle periods.
// Depends on swr_pkg, swr_cfg_regs and swr_wheel_ramp.
module wheel_setpoint_ramp_with_kick (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_op,
    input  logic [2:0]                            i_key,
    input  logic [1:0]                            i_command,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [swr_pkg::SP_W-1:0]       o_left_target,
    output logic signed [swr_pkg::SP_W-1:0]       o_right_target,
    output logic                                  o_running,
    output logic [1:0]                            o_direction,
    output logic                                  o_armed,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [swr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [swr_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    swr_pkg::t_cfg cfg;

    logic       r_in_valid;
    logic [1:0] r_op;
    logic [2:0] r_key;
    logic [1:0] r_cmd;
    logic       r_out_valid;

    logic                            r_armed, n_armed;
    logic [1:0]                      r_dir, n_dir;
    logic signed [swr_pkg::SP_W-1:0] r_left, n_left;
    logic signed [swr_pkg::SP_W-1:0] r_right, n_right;
    logic                            r_running, n_running;

    logic                            advance;
    logic                            armed_key;
    logic signed [swr_pkg::SP_W-1:0] dest;
    logic signed [swr_pkg::SP_W-1:0] left_ramp;
    logic signed [swr_pkg::SP_W-1:0] right_ramp;

    assign o_cfg_ready = 1'b1;

    swr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_cmd <= i_command;
        end
    end

    always_comb begin
        unique case (r_dir)
            swr_pkg::DIR_FWD: dest = $signed({1'b0, cfg.cruise});
            swr_pkg::DIR_BWD: dest = -$signed({1'b0, cfg.cruise});
            default:          dest = '0;
        endcase
    end

    swr_wheel_ramp u_left (
        .i_sp        (r_left),
        .i_dest      (dest),
        .i_step      (cfg.step),
        .i_kick_fwd  (cfg.kick_lf),
        .i_kick_back (cfg.kick_back),
        .o_sp        (left_ramp)
    );

    swr_wheel_ramp u_right (
        .i_sp        (r_right),
        .i_dest      (dest),
        .i_step      (cfg.step),
        .i_kick_fwd  (cfg.kick_rf),
        .i_kick_back (cfg.kick_back),
        .o_sp        (right_ramp)
    );

    assign armed_key = r_armed || (r_key == swr_pkg::KEY_ARM);

    always_comb begin
        n_armed   = r_armed;
        n_dir     = r_dir;
        n_left    = r_left;
        n_right   = r_right;
        n_running = r_running;
        if (advance && r_in_valid) begin
            unique case (r_op)
                swr_pkg::OP_KEY: begin
                    n_armed = armed_key;
                    if (r_key == swr_pkg::KEY_ARM) begin
                        n_dir = swr_pkg::DIR_STOP;
                    end
                    if (armed_key) begin
                        if (r_key == swr_pkg::KEY_FWD) begin
                            n_dir = swr_pkg::DIR_FWD;
                        end else if (r_key == swr_pkg::KEY_BWD) begin
                            n_dir = swr_pkg::DIR_BWD;
                        end else if (r_key == swr_pkg::KEY_STOP) begin
                            n_dir = swr_pkg::DIR_STOP;
                        end
                    end
                end
                swr_pkg::OP_TICK: begin
                    if (!r_armed) begin
                        n_left    = '0;
                        n_right   = '0;
                        n_dir     = swr_pkg::DIR_STOP;
                        n_running = 1'b0;
                    end else begin
                        n_left  = left_ramp;
                        n_right = right_ramp;
                        if (r_dir == swr_pkg::DIR_FWD || r_dir == swr_pkg::DIR_BWD) begin
                            n_running = 1'b1;
                        end
                        if (r_dir == swr_pkg::DIR_STOP && left_ramp == '0
                                && right_ramp == '0) begin
                            n_running = 1'b0;
                        end
                    end
                end
                swr_pkg::OP_CMD: begin
                    if (r_cmd != swr_pkg::DIR_BAD) begin
                        n_dir = r_cmd;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_dir     <= swr_pkg::DIR_STOP;
            r_left    <= '0;
            r_right   <= '0;
            r_running <= 1'b0;
        end else begin
            r_armed   <= n_armed;
            r_dir     <= n_dir;
            r_left    <= n_left;
            r_right   <= n_right;
            r_running <= n_running;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_target  = r_left;
    assign o_right_target = r_right;
    assign o_running      = r_running;
    assign o_direction    = r_dir;
    assign o_armed        = r_armed;

endmodule

/* hdl/swr_checker.sv */
// Port-level checks for the wheel setpoint ramp, bound to its top level.
// Depends on swr_pkg and wheel_setpoint_ramp_with_kick.
module swr_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_in_ready,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [swr_pkg::SP_W-1:0]       o_left_target,
    input  logic signed [swr_pkg::SP_W-1:0]       o_right_target,
    input  logic                                  o_running,
    input  logic [1:0]                            o_direction,
    input  logic                                  o_armed
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_left_target)
            && $stable(o_right_target) && $stable(o_running)
            && $stable(o_direction) && $stable(o_armed)))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused with empty result stage");

    a_unarmed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_armed) |-> (!o_running && o_left_target == '0
            && o_right_target == '0))
        else $error("unarmed block drives wheels");

    a_armed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_armed |=> o_armed)
        else $error("armed flag dropped");

endmodule

bind wheel_setpoint_ramp_with_kick swr_checker u_swr_checker (.*);
